[rtl/histeq_pkg.sv]
// Package for the histogram equalisation block: widths, constants and the
// sequencer state type. It has no dependencies.
package histeq_pkg;

    // Width of the pixel total before it saturates.
    localparam int TOTAL_BITS = 20;
    // Width of a bin count and of the pixel total.
    localparam int CNT_W      = TOTAL_BITS + 1;
    // Width of a gray value and of a table index.
    localparam int PIX_W      = 8;
    localparam int BINS       = 256;
    // Quotient bits of one table entry.
    localparam int QUOT_W     = 8;
    // Width of 255 times a cumulative count.
    localparam int NUM_W      = CNT_W + QUOT_W;
    localparam int STEP_W     = $clog2(QUOT_W);

    localparam logic [PIX_W-1:0] MAX_GRAY = PIX_W'(255);

    // Input item actions.
    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_MAP   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT_WR,
        S_MAP_OUT,
        S_B_RD,
        S_B_ACC,
        S_B_DIV,
        S_B_WR
    } t_state;

endpackage

[rtl/histeq_div.sv]
// Iterative restoring divider giving one quotient bit per cycle.
// Depends on histeq_pkg for its widths.
module histeq_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [histeq_pkg::NUM_W-1:0]   i_num,
    input  logic [histeq_pkg::CNT_W-1:0]   i_den,
    output logic                           o_done,
    output logic [histeq_pkg::QUOT_W-1:0]  o_quot
);

    logic                             r_busy;
    logic                             r_done;
    logic [histeq_pkg::STEP_W-1:0]    r_step;
    logic [histeq_pkg::NUM_W-1:0]     r_rem;
    logic [histeq_pkg::NUM_W-1:0]     r_dsh;
    logic [histeq_pkg::QUOT_W-1:0]    r_quot;
    logic                             fits;
    logic                             last_step;

    // The divisor is aligned to the top quotient bit and walks down a bit a cycle.
    assign fits      = (r_rem >= r_dsh);
    assign last_step = (r_step == histeq_pkg::STEP_W'(histeq_pkg::QUOT_W - 1));

    // Control: busy while the quotient bits are formed, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + histeq_pkg::STEP_W'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: one compare and subtract per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {1'b0, i_den, {(histeq_pkg::QUOT_W - 1){1'b0}}};
            r_quot <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quot <= {r_quot[histeq_pkg::QUOT_W-2:0], fits};
            r_dsh  <= {1'b0, r_dsh[histeq_pkg::NUM_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[rtl/histogram_equalization.sv]
// Top level of the histogram equalisation block: histogram and table memories,
// sequencer and output register. Depends on histeq_pkg and histeq_div.
//
// A count item (action 0) adds its pixel to a 256-bin histogram; a map item
// (action 1) returns the table entry for its pixel once the output register
// is free. A count item marked last then rebuilds the mapping table as
// floor(255 * cumulative / total): each of the 256 bins costs one histogram
// read, one accumulate, a run of the shared bit-serial divider (eight
// quotient bits and a done pulse) and one table write, with the divider
// skipped while the total is zero, and the input stays stalled for the whole
// build. The histogram and table reset through per-entry valid bits, so there
// is no clearing pass after reset, and the histogram is cleared at once at
// the end of a build. The pixel total saturates at 2^TOTAL_BITS; once there,
// further count items are not counted.
module histogram_equalization (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [histeq_pkg::PIX_W-1:0]  i_pixel,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [histeq_pkg::PIX_W-1:0]  o_equalized
);

    histeq_pkg::t_state r_state, n_state;

    // Memories with reset through valid bits.
    logic [histeq_pkg::CNT_W-1:0]  bin_mem [histeq_pkg::BINS];
    logic [histeq_pkg::PIX_W-1:0]  map_mem [histeq_pkg::BINS];
    logic [histeq_pkg::BINS-1:0]   r_bin_vld;
    logic [histeq_pkg::BINS-1:0]   r_map_vld;
    logic [histeq_pkg::CNT_W-1:0]  r_bin_rd;
    logic                          r_bin_rd_vld;
    logic [histeq_pkg::PIX_W-1:0]  r_map_rd;
    logic                          r_map_rd_vld;

    logic [histeq_pkg::PIX_W-1:0]  r_pix;
    logic                          r_last;
    logic [histeq_pkg::CNT_W-1:0]  r_total;
    logic [histeq_pkg::PIX_W-1:0]  r_idx;
    logic [histeq_pkg::CNT_W-1:0]  r_running;
    logic [histeq_pkg::CNT_W-1:0]  n_running;
    logic                          r_out_valid;
    logic [histeq_pkg::PIX_W-1:0]  r_equalized;

    logic [histeq_pkg::PIX_W-1:0]  bin_addr;
    logic [histeq_pkg::CNT_W-1:0]  bin_val;
    logic [histeq_pkg::NUM_W-1:0]  div_num;
    logic [histeq_pkg::QUOT_W-1:0] div_quot;
    logic                          div_done;
    logic                          total_zero;
    logic                          at_limit;
    logic                          in_acc;
    logic                          out_free;

    // Strobes from the sequencer.
    logic cnt_we;
    logic map_we;
    logic div_start;
    logic out_load;
    logic build_init;
    logic build_next;
    logic build_end;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign bin_addr   = (r_state == histeq_pkg::S_IDLE) ? i_pixel : r_idx;
    assign bin_val    = r_bin_rd_vld ? r_bin_rd : '0;
    assign total_zero = (r_total == '0);
    assign at_limit   = r_total[histeq_pkg::TOTAL_BITS];
    assign n_running  = r_running + bin_val;
    // 255 times the cumulative count, as a shift and a subtract.
    assign div_num    = {n_running, {histeq_pkg::QUOT_W{1'b0}}}
                        - {{histeq_pkg::QUOT_W{1'b0}}, n_running};

    histeq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= histeq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes.
    always_comb begin
        n_state    = r_state;
        cnt_we     = 1'b0;
        map_we     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        build_init = 1'b0;
        build_next = 1'b0;
        build_end  = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            histeq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = (i_action == histeq_pkg::ACT_MAP) ?
                              histeq_pkg::S_MAP_OUT : histeq_pkg::S_CNT_WR;
                end
            end
            histeq_pkg::S_CNT_WR: begin
                cnt_we = !at_limit;
                if (r_last) begin
                    build_init = 1'b1;
                    n_state    = histeq_pkg::S_B_RD;
                end else begin
                    n_state = histeq_pkg::S_IDLE;
                end
            end
            histeq_pkg::S_MAP_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = histeq_pkg::S_IDLE;
                end
            end
            histeq_pkg::S_B_RD: begin
                n_state = histeq_pkg::S_B_ACC;
            end
            histeq_pkg::S_B_ACC: begin
                // An empty histogram maps everything to zero without dividing.
                if (total_zero) begin
                    n_state = histeq_pkg::S_B_WR;
                end else begin
                    div_start = 1'b1;
                    n_state   = histeq_pkg::S_B_DIV;
                end
            end
            histeq_pkg::S_B_DIV: begin
                if (div_done) begin
                    n_state = histeq_pkg::S_B_WR;
                end
            end
            histeq_pkg::S_B_WR: begin
                map_we = 1'b1;
                if (r_idx == histeq_pkg::MAX_GRAY) begin
                    build_end = 1'b1;
                    n_state   = histeq_pkg::S_IDLE;
                end else begin
                    build_next = 1'b1;
                    n_state    = histeq_pkg::S_B_RD;
                end
            end
            default: begin
                n_state = histeq_pkg::S_IDLE;
            end
        endcase
    end

    // Histogram memory: one read and one write port.
    always_ff @(posedge i_clk) begin
        r_bin_rd <= bin_mem[bin_addr];
        if (cnt_we) begin
            bin_mem[r_pix] <= bin_val + histeq_pkg::CNT_W'(1);
        end
    end

    // Mapping table memory; the read is taken when an item is accepted and
    // held until the result is loaded.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_map_rd <= map_mem[i_pixel];
        end
        if (map_we) begin
            map_mem[r_idx] <= total_zero ? '0 : div_quot;
        end
    end

    // Valid bits, sampled alongside each memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_vld    <= '0;
            r_map_vld    <= '0;
            r_bin_rd_vld <= 1'b0;
            r_map_rd_vld <= 1'b0;
        end else begin
            r_bin_rd_vld <= r_bin_vld[bin_addr];
            if (in_acc) begin
                r_map_rd_vld <= r_map_vld[i_pixel];
            end
            if (build_end) begin
                r_bin_vld <= '0;
            end else if (cnt_we) begin
                r_bin_vld[r_pix] <= 1'b1;
            end
            if (map_we) begin
                r_map_vld[r_idx] <= 1'b1;
            end
        end
    end

    // Captured item fields.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix  <= i_pixel;
            r_last <= i_last;
        end
    end

    // Pixel total, saturating at the limit and cleared after a build.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (build_end) begin
            r_total <= '0;
        end else if (cnt_we) begin
            r_total <= r_total + histeq_pkg::CNT_W'(1);
        end
    end

    // Build index and running cumulative count.
    always_ff @(posedge i_clk) begin
        if (build_init) begin
            r_idx     <= '0;
            r_running <= '0;
        end else begin
            if (r_state == histeq_pkg::S_B_ACC) begin
                r_running <= n_running;
            end
            if (build_next) begin
                r_idx <= r_idx + histeq_pkg::PIX_W'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_equalized <= r_map_rd_vld ? r_map_rd : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_equalized = r_equalized;

endmodule

[rtl/histeq_chk.sv]
// Port checker for the histogram equalisation block, bound to the top level.
// Depends on histeq_pkg for the pixel width and the action codes.
module histeq_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_action,
    input logic [histeq_pkg::PIX_W-1:0]  i_pixel,
    input logic                          i_last,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [histeq_pkg::PIX_W-1:0]  o_equalized
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_equalized))
        else $error("stalled result changed or dropped");

    // The block stalls its input once it has accepted an item.
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("item accepted in consecutive cycles");

    // A count item taken while no result is pending does not raise one.
    a_count_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_action == histeq_pkg::ACT_COUNT) && !o_out_valid
        |=> !o_out_valid)
        else $error("count item produced a result");

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind histogram_equalization histeq_chk u_histeq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_action    (i_action),
    .i_pixel     (i_pixel),
    .i_last      (i_last),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_equalized (o_equalized)
);
